// File: rtl/core/shbt_pkg.sv
// ----------------------------------------------------------------------------
// shbt_pkg
// Shared types, sizes and constants of the spatial hash bucket table.
// ----------------------------------------------------------------------------
`default_nettype none

package shbt_pkg;

    // table geometry (bucket count must be a power of two)
    localparam int HASH_BUCKETS = 1024;
    localparam int BUCKET_SLOTS = 8;
    localparam int MAX_RESULTS  = 8;

    localparam int BUCKET_W    = $clog2(HASH_BUCKETS);
    localparam int SLOT_W      = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
    localparam int FILL_W      = $clog2(BUCKET_SLOTS + 1);
    localparam int ENTRY_DEPTH = HASH_BUCKETS * BUCKET_SLOTS;
    localparam int ENTRY_AW    = $clog2(ENTRY_DEPTH);
    localparam int RES_K_W     = $clog2(MAX_RESULTS);
    localparam int RES_N_W     = $clog2(MAX_RESULTS + 1);

    // field widths
    localparam int ID_W    = 16;
    localparam int COORD_W = 32;
    localparam int CSIZE_W = 16;
    localparam int COUNT_W = 14;
    localparam int CELL_W  = 24;

    localparam logic [CSIZE_W-1:0] CELL_SIZE_RESET = 16'd64;
    localparam logic [31:0] PRIME_X = 32'd73856093;
    localparam logic [31:0] PRIME_Y = 32'd19349663;

    // operation codes
    localparam logic [2:0] MODE_INSERT = 3'd0;
    localparam logic [2:0] MODE_REMOVE = 3'd1;
    localparam logic [2:0] MODE_POINT  = 3'd2;
    localparam logic [2:0] MODE_BOX    = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_EMPTY     = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_HASH,
        S_FILL_RD,
        S_DISPATCH,
        S_RM_RD,
        S_RM_CMP,
        S_SH_RD,
        S_SH_WR,
        S_RM_DONE,
        S_Q_RD,
        S_Q_EMIT,
        S_RESULT
    } state_t;

    // divider handshake toward the sequencer
    typedef struct packed {
        logic done;
    } div_status_t;

    // flat entry address of a bucket slot
    function automatic logic [ENTRY_AW-1:0] entry_addr(
        input logic [BUCKET_W-1:0] bucket,
        input logic [SLOT_W-1:0]   slot
    );
        return ENTRY_AW'(bucket) * ENTRY_AW'(BUCKET_SLOTS) + ENTRY_AW'(slot);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/shbt_if.sv
// ----------------------------------------------------------------------------
// shbt_if
// Request and response channels of the spatial hash bucket table.
// ----------------------------------------------------------------------------
`default_nettype none

interface shbt_req_if;
    logic                                valid;
    logic                                ready;
    logic [2:0]                          mode;
    logic [shbt_pkg::ID_W-1:0]           body_id;
    logic signed [shbt_pkg::COORD_W-1:0] min_x;
    logic signed [shbt_pkg::COORD_W-1:0] min_y;
    logic signed [shbt_pkg::COORD_W-1:0] max_x;
    logic signed [shbt_pkg::COORD_W-1:0] max_y;

    modport source (output valid, mode, body_id, min_x, min_y, max_x, max_y,
                    input ready);
    modport sink   (input valid, mode, body_id, min_x, min_y, max_x, max_y,
                    output ready);
endinterface

interface shbt_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [shbt_pkg::ID_W-1:0]        found_id;
    logic [shbt_pkg::BUCKET_W-1:0]    bucket_index;
    logic [1:0]                       status;
    logic                             last;
    logic [shbt_pkg::COUNT_W-1:0]     active_count;

    modport source (output valid, found_id, bucket_index, status, last,
                    active_count, input ready);
    modport sink   (input valid, found_id, bucket_index, status, last,
                    active_count, output ready);
endinterface

`default_nettype wire

// File: rtl/core/shbt_ram.sv
// ----------------------------------------------------------------------------
// shbt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module shbt_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data holds while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/shbt_floor_div.sv
// ----------------------------------------------------------------------------
// shbt_floor_div
// Bit-serial floor division of a signed cell coordinate by the cell size.
// ----------------------------------------------------------------------------
`default_nettype none

module shbt_floor_div (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic signed [shbt_pkg::CELL_W-1:0]  dividend,
    input  wire logic [shbt_pkg::CSIZE_W-1:0]        divisor,
    output shbt_pkg::div_status_t                    stat,
    output logic signed [shbt_pkg::CELL_W-1:0]       quotient
);

    localparam int CW  = shbt_pkg::CELL_W;
    localparam int DW  = shbt_pkg::CSIZE_W;
    localparam int CNW = $clog2(CW + 1);

    logic           busy_reg;
    logic           done_reg;
    logic           neg_reg;
    logic [CW-1:0]  quo_reg;
    logic [DW-1:0]  rem_reg;
    logic [DW-1:0]  den_reg;
    logic [CNW-1:0] cnt_reg;

    logic [DW:0]    shift_val;
    logic           ge;
    logic [DW:0]    diff;

    // one restoring step per cycle
    assign shift_val = {rem_reg, quo_reg[CW-1]};
    assign ge        = shift_val >= {1'b0, den_reg};
    assign diff      = shift_val - {1'b0, den_reg};

    // negative values: floor(n/d) = ~(~n / d)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNW'(CW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNW'(1);
            if (cnt_reg == CNW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[CW-1];
            quo_reg <= dividend[CW-1] ? ~dividend : dividend;
            rem_reg <= '0;
            den_reg <= (divisor == '0) ? DW'(1) : divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DW-1:0] : shift_val[DW-1:0];
            quo_reg <= {quo_reg[CW-2:0], ge};
        end
    end

    assign stat.done = done_reg;
    assign quotient  = neg_reg ? ~quo_reg : quo_reg;

endmodule

`default_nettype wire

// File: rtl/core/spatial_hash_bucket_table_unit.sv
// ----------------------------------------------------------------------------
// spatial_hash_bucket_table_unit
// 2D spatial hash of body ids into fixed-size buckets with query listing.
// ----------------------------------------------------------------------------
// Processes one transaction at a time. Insert, remove and query first run two
// parallel bit-serial floor divisions, then the hash multiply, a bucket-fill
// read and, for a remove or a query, the bucket walk; output back-pressure
// can stall the result. The bucket slot RAM has a single read port, so the
// walk reads one slot at a time.
// A clear returns its result and then sweeps the fill memory, one bucket per
// cycle; the same sweep runs after reset. No request is taken during a sweep;
// cell_size writes are taken in every state, also while busy.
`default_nettype none

module spatial_hash_bucket_table_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [shbt_pkg::CSIZE_W-1:0]      cfg_wdata,
    shbt_req_if.sink                               req,
    shbt_rsp_if.source                             rsp
);

    localparam int BW = shbt_pkg::BUCKET_W;
    localparam int SW = shbt_pkg::SLOT_W;
    localparam int FW = shbt_pkg::FILL_W;
    localparam int CW = shbt_pkg::CELL_W;
    localparam int KW = shbt_pkg::RES_K_W;
    localparam int NW = shbt_pkg::RES_N_W;
    localparam int AW = shbt_pkg::ENTRY_AW;

    shbt_pkg::state_t state_reg, state_next;

    // configuration and counters
    logic [shbt_pkg::CSIZE_W-1:0] cell_size_reg;
    logic [shbt_pkg::COUNT_W-1:0] active_reg;
    logic [BW-1:0]                clr_cnt_reg;
    logic                         clr_pend_reg;

    // item context
    logic [2:0]                   mode_reg;
    logic [shbt_pkg::ID_W-1:0]    id_reg;
    logic [31:0]                  hx_reg;
    logic [31:0]                  hy_reg;
    logic [BW-1:0]                bucket_reg;
    logic [FW-1:0]                fill_reg;
    logic [SW-1:0]                slot_reg;
    logic [KW-1:0]                k_reg;
    logic [NW-1:0]                n_reg;
    logic [shbt_pkg::ID_W-1:0]    res_id_reg;
    shbt_pkg::status_t            res_status_reg;

    // output register
    logic                         out_valid_reg;
    logic [shbt_pkg::ID_W-1:0]    out_id_reg;
    logic [BW-1:0]                out_bucket_reg;
    logic [1:0]                   out_status_reg;
    logic                         out_last_reg;
    logic [shbt_pkg::COUNT_W-1:0] out_count_reg;

    logic req_fire;
    logic out_free;
    logic div_start;
    logic signed [CW-1:0] dvd_x, dvd_y, quo_x, quo_y;
    logic signed [shbt_pkg::COORD_W:0] sum_x, sum_y;
    shbt_pkg::div_status_t div_x_stat, div_y_stat;
    logic [BW-1:0] hash_bucket;
    logic [SW-1:0] q_slot;
    logic          rm_match;
    logic          q_last;

    // memory ports
    logic                        fill_we, fill_re;
    logic [BW-1:0]               fill_waddr;
    logic [FW-1:0]               fill_wdata, fill_rdata;
    logic                        ent_we, ent_re;
    logic [AW-1:0]               ent_waddr, ent_raddr;
    logic [shbt_pkg::ID_W-1:0]   ent_wdata, ent_rdata;

    assign req_fire = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    // cell coordinates: point uses x / 256, box uses (min + max) / 512
    assign sum_x = {req.min_x[shbt_pkg::COORD_W-1], req.min_x}
                 + {req.max_x[shbt_pkg::COORD_W-1], req.max_x};
    assign sum_y = {req.min_y[shbt_pkg::COORD_W-1], req.min_y}
                 + {req.max_y[shbt_pkg::COORD_W-1], req.max_y};
    assign dvd_x = (req.mode == shbt_pkg::MODE_POINT) ? req.min_x[31:8] : sum_x[32:9];
    assign dvd_y = (req.mode == shbt_pkg::MODE_POINT) ? req.min_y[31:8] : sum_y[32:9];
    assign div_start = req_fire && (req.mode < shbt_pkg::MODE_CLEAR);

    shbt_floor_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_x),
        .divisor  (cell_size_reg),
        .stat     (div_x_stat),
        .quotient (quo_x)
    );

    shbt_floor_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_y),
        .divisor  (cell_size_reg),
        .stat     (div_y_stat),
        .quotient (quo_y)
    );

    // per-bucket fill counts
    shbt_ram #(.DEPTH(shbt_pkg::HASH_BUCKETS), .WIDTH(FW)) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wdata),
        .re    (fill_re),
        .raddr (hash_bucket),
        .rdata (fill_rdata)
    );

    // bucket slots, oldest id at slot 0
    shbt_ram #(.DEPTH(shbt_pkg::ENTRY_DEPTH), .WIDTH(shbt_pkg::ID_W)) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    assign hash_bucket = BW'(hx_reg ^ hy_reg);
    assign q_slot      = SW'(fill_reg - FW'(1) - FW'(k_reg));
    assign rm_match    = (ent_rdata == id_reg);
    assign q_last      = (NW'(k_reg) + NW'(1) == n_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            shbt_pkg::S_CLEAR:
                if (clr_cnt_reg == BW'(shbt_pkg::HASH_BUCKETS - 1))
                    state_next = shbt_pkg::S_IDLE;
            shbt_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.mode == shbt_pkg::MODE_CLEAR)
                        state_next = shbt_pkg::S_RESULT;
                    else if (req.mode < shbt_pkg::MODE_CLEAR)
                        state_next = shbt_pkg::S_DIV;
                end
            end
            shbt_pkg::S_DIV:
                if (div_x_stat.done && div_y_stat.done)
                    state_next = shbt_pkg::S_HASH;
            shbt_pkg::S_HASH:
                state_next = shbt_pkg::S_FILL_RD;
            shbt_pkg::S_FILL_RD:
                state_next = shbt_pkg::S_DISPATCH;
            shbt_pkg::S_DISPATCH:
            begin
                if (mode_reg == shbt_pkg::MODE_INSERT || fill_rdata == '0)
                    state_next = shbt_pkg::S_RESULT;
                else if (mode_reg == shbt_pkg::MODE_REMOVE)
                    state_next = shbt_pkg::S_RM_RD;
                else
                    state_next = shbt_pkg::S_Q_RD;
            end
            shbt_pkg::S_RM_RD:
                state_next = shbt_pkg::S_RM_CMP;
            shbt_pkg::S_RM_CMP:
            begin
                if (rm_match)
                begin
                    if ({1'b0, FW'(slot_reg)} + (FW+1)'(1) < {1'b0, fill_reg})
                        state_next = shbt_pkg::S_SH_RD;
                    else
                        state_next = shbt_pkg::S_RM_DONE;
                end
                else if (slot_reg == '0)
                    state_next = shbt_pkg::S_RESULT;
                else
                    state_next = shbt_pkg::S_RM_RD;
            end
            shbt_pkg::S_SH_RD:
                state_next = shbt_pkg::S_SH_WR;
            shbt_pkg::S_SH_WR:
            begin
                if ({1'b0, FW'(slot_reg)} + (FW+1)'(2) < {1'b0, fill_reg})
                    state_next = shbt_pkg::S_SH_RD;
                else
                    state_next = shbt_pkg::S_RM_DONE;
            end
            shbt_pkg::S_RM_DONE:
                state_next = shbt_pkg::S_RESULT;
            shbt_pkg::S_Q_RD:
                state_next = shbt_pkg::S_Q_EMIT;
            shbt_pkg::S_Q_EMIT:
            begin
                if (out_free)
                    state_next = q_last ? shbt_pkg::S_IDLE : shbt_pkg::S_Q_RD;
            end
            shbt_pkg::S_RESULT:
            begin
                if (out_free)
                    state_next = clr_pend_reg ? shbt_pkg::S_CLEAR : shbt_pkg::S_IDLE;
            end
            default:
                state_next = shbt_pkg::S_IDLE;
        endcase
    end

    // memory control and handshake outputs
    always_comb
    begin
        req.ready  = (state_reg == shbt_pkg::S_IDLE);
        fill_we    = 1'b0;
        fill_waddr = bucket_reg;
        fill_wdata = '0;
        fill_re    = (state_reg == shbt_pkg::S_FILL_RD);
        ent_we     = 1'b0;
        ent_waddr  = shbt_pkg::entry_addr(bucket_reg, slot_reg);
        ent_wdata  = ent_rdata;
        ent_re     = 1'b0;
        ent_raddr  = shbt_pkg::entry_addr(bucket_reg, slot_reg);
        unique case (state_reg)
            shbt_pkg::S_CLEAR:
            begin
                fill_we    = 1'b1;
                fill_waddr = clr_cnt_reg;
            end
            shbt_pkg::S_DISPATCH:
            begin
                if (mode_reg == shbt_pkg::MODE_INSERT &&
                    fill_rdata < FW'(shbt_pkg::BUCKET_SLOTS))
                begin
                    fill_we    = 1'b1;
                    fill_wdata = fill_rdata + FW'(1);
                    ent_we     = 1'b1;
                    ent_waddr  = shbt_pkg::entry_addr(bucket_reg, SW'(fill_rdata));
                    ent_wdata  = id_reg;
                end
            end
            shbt_pkg::S_RM_RD:
                ent_re = 1'b1;
            shbt_pkg::S_SH_RD:
            begin
                ent_re    = 1'b1;
                ent_raddr = shbt_pkg::entry_addr(bucket_reg, slot_reg + SW'(1));
            end
            shbt_pkg::S_SH_WR:
                ent_we = 1'b1;
            shbt_pkg::S_RM_DONE:
            begin
                fill_we    = 1'b1;
                fill_wdata = fill_reg - FW'(1);
            end
            shbt_pkg::S_Q_RD:
            begin
                ent_re    = 1'b1;
                ent_raddr = shbt_pkg::entry_addr(bucket_reg, q_slot);
            end
            default:
            begin
                ent_re = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= shbt_pkg::S_CLEAR;
            cell_size_reg <= shbt_pkg::CELL_SIZE_RESET;
            active_reg    <= '0;
            clr_cnt_reg   <= '0;
            clr_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                cell_size_reg <= cfg_wdata;
            if (state_reg == shbt_pkg::S_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + BW'(1);
            if (req_fire && req.mode == shbt_pkg::MODE_CLEAR)
            begin
                active_reg   <= '0;
                clr_pend_reg <= 1'b1;
                clr_cnt_reg  <= '0;
            end
            else if (state_reg == shbt_pkg::S_RESULT && out_free)
                clr_pend_reg <= 1'b0;
            if (fill_we && state_reg == shbt_pkg::S_DISPATCH)
                active_reg <= active_reg + shbt_pkg::COUNT_W'(1);
            else if (state_reg == shbt_pkg::S_RM_DONE && active_reg != '0)
                active_reg <= active_reg - shbt_pkg::COUNT_W'(1);
            if ((state_reg == shbt_pkg::S_RESULT || state_reg == shbt_pkg::S_Q_EMIT)
                && out_free)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // item datapath
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            mode_reg       <= req.mode;
            id_reg         <= req.body_id;
            res_id_reg     <= req.body_id;
            res_status_reg <= shbt_pkg::STATUS_OK;
            bucket_reg     <= '0;
        end
        if (state_reg == shbt_pkg::S_HASH)
        begin
            hx_reg <= 32'({{(32 - CW){quo_x[CW-1]}}, quo_x} * shbt_pkg::PRIME_X);
            hy_reg <= 32'({{(32 - CW){quo_y[CW-1]}}, quo_y} * shbt_pkg::PRIME_Y);
        end
        if (state_reg == shbt_pkg::S_FILL_RD)
            bucket_reg <= hash_bucket;
        if (state_reg == shbt_pkg::S_DISPATCH)
        begin
            fill_reg <= fill_rdata;
            slot_reg <= SW'(fill_rdata - FW'(1));
            k_reg    <= '0;
            n_reg    <= (int'(fill_rdata) > shbt_pkg::MAX_RESULTS) ?
                        NW'(shbt_pkg::MAX_RESULTS) : NW'(fill_rdata);
            if (mode_reg == shbt_pkg::MODE_INSERT)
            begin
                if (fill_rdata >= FW'(shbt_pkg::BUCKET_SLOTS))
                    res_status_reg <= shbt_pkg::STATUS_FULL;
            end
            else if (mode_reg == shbt_pkg::MODE_REMOVE)
            begin
                if (fill_rdata == '0)
                    res_status_reg <= shbt_pkg::STATUS_NOT_FOUND;
            end
            else if (fill_rdata == '0)
            begin
                res_id_reg     <= '0;
                res_status_reg <= shbt_pkg::STATUS_EMPTY;
            end
        end
        if (state_reg == shbt_pkg::S_RM_CMP && !rm_match)
        begin
            if (slot_reg == '0)
                res_status_reg <= shbt_pkg::STATUS_NOT_FOUND;
            else
                slot_reg <= slot_reg - SW'(1);
        end
        if (state_reg == shbt_pkg::S_SH_WR)
            slot_reg <= slot_reg + SW'(1);
        if (state_reg == shbt_pkg::S_Q_EMIT && out_free)
            k_reg <= k_reg + KW'(1);
        // load the output register
        if (state_reg == shbt_pkg::S_RESULT && out_free)
        begin
            out_id_reg     <= res_id_reg;
            out_bucket_reg <= bucket_reg;
            out_status_reg <= res_status_reg;
            out_last_reg   <= 1'b1;
            out_count_reg  <= active_reg;
        end
        else if (state_reg == shbt_pkg::S_Q_EMIT && out_free)
        begin
            out_id_reg     <= ent_rdata;
            out_bucket_reg <= bucket_reg;
            out_status_reg <= shbt_pkg::STATUS_OK;
            out_last_reg   <= q_last;
            out_count_reg  <= active_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.found_id     = out_id_reg;
    assign rsp.bucket_index = out_bucket_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.last         = out_last_reg;
    assign rsp.active_count = out_count_reg;

    // fill counts written back never exceed the slot count
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_we |-> fill_wdata <= FW'(shbt_pkg::BUCKET_SLOTS))
        else $error("fill count above slot count");

    // dispatch consumes the fill data read in the cycle before it
    a_fill_latency: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == shbt_pkg::S_DISPATCH |-> $past(state_reg) == shbt_pkg::S_FILL_RD)
        else $error("fill read data used at wrong latency");

    // no request is taken while the fill memory is swept
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == shbt_pkg::S_CLEAR |-> !req.ready)
        else $error("request accepted during clear sweep");

    // the total never exceeds the table capacity
    a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg <= shbt_pkg::COUNT_W'(shbt_pkg::ENTRY_DEPTH))
        else $error("active count above capacity");

endmodule

`default_nettype wire
